@@ rtl/core/lav_pkg.sv @@
// Shared types, constants and helper functions for the look-at view matrix block.
package lav_pkg;

	// Fixed widths of the ports and of the internal datapath.
	localparam int WORD_W = 32;
	localparam int FRAC = 16;
	localparam int CMD_W = 2;
	localparam int IDX_W = 2;
	localparam int MAG_W = 50;
	localparam int OPW = 33;
	localparam int PROD_W = 2 * OPW;
	localparam int ACC_W = 64;
	localparam int FW = 18;
	localparam int UW = 19;
	localparam int LEN_W = 32;
	localparam int NMAG_W = 30;
	localparam int NUM_W = NMAG_W + FRAC + 1;
	localparam int QB = 18;
	localparam int OUT_DATA_W = 4 * WORD_W;
	localparam int OUT_USER_W = 3;
	localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) <<< FRAC;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);

	// Input command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_MOVE_X = 2'd0,
		CMD_MOVE_Y = 2'd1,
		CMD_MOVE_Z = 2'd2,
		CMD_VIEW   = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_UP_X = 2'd0,
		REG_UP_Y = 2'd1,
		REG_UP_Z = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	// Which product sequence the shared multiplier runs.
	typedef enum logic [1:0] {
		PH_SQ    = 2'd0,
		PH_CROSS = 2'd1,
		PH_UP    = 2'd2,
		PH_DOT   = 2'd3
	} phase_t;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_NORM  = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_ACC   = 8'b0000_1000,
		ST_SQRT  = 8'b0001_0000,
		ST_DLOAD = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	// Saturating add of two words.
	function automatic logic signed [WORD_W-1:0] sat_add(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
		if (s[WORD_W] != s[WORD_W-1]) begin
			sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			sat_add = s[WORD_W-1:0];
		end
	endfunction

	// Shift right by the fraction width, rounding half toward plus infinity.
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x);
		rnd = (x + HALF) >>> FRAC;
	endfunction

	// Clamp a wide value to the word range.
	function automatic logic signed [WORD_W-1:0] clamp_word(input logic signed [ACC_W-1:0] x);
		if (x > $signed(ACC_W'({1'b0, {(WORD_W-1){1'b1}}}))) begin
			clamp_word = {1'b0, {(WORD_W-1){1'b1}}};
		end else if (x < -(ACC_W'(1) <<< (WORD_W - 1))) begin
			clamp_word = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			clamp_word = x[WORD_W-1:0];
		end
	endfunction

endpackage

@@ rtl/core/look_at_view_matrix.sv @@
// Top level of the look-at view matrix block: camera state, sequencer and shared arithmetic.
//
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser = cmd, tdata = amount
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata = entries, tuser = group/degenerate
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data (world up vector)
//
// A move transaction updates eye and target in the idle state. A view transaction
// runs the normalizing shifts, the single shared multiplier, the 32-step square root
// and the 18-step divider that each of the two normalizations runs.
// A zero forward vector skips both roots.
// The four result groups then leave one per accepted output transaction.
// Reset restores up (0, 1, 0), eye (0, 0, 1) and target (0, 0, 0).
// While a view is computed or its groups wait, no input is taken; cfg is always ready.
module look_at_view_matrix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lav_pkg::WORD_W-1:0]         s_axis_tdata,  // amount
	input  logic [lav_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lav_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // entry_a, entry_b, entry_c, entry_d
	output logic [lav_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // group_index[1:0], degenerate
	output logic                               m_axis_tlast,  // last
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lav_pkg::IDX_W-1:0]          cfg_index,
	input  logic [lav_pkg::WORD_W-1:0]         cfg_data
);
	import lav_pkg::*;

	state_t state_q;
	phase_t phase_q;

	logic signed [WORD_W-1:0] up_q [3];
	logic signed [WORD_W-1:0] eye_q [3];
	logic signed [WORD_W-1:0] tgt_q [3];
	logic [MAG_W-1:0] mag_q [3];
	logic neg_q [3];
	logic signed [FW-1:0] f_q [3];
	logic signed [FW-1:0] l_q [3];
	logic signed [UW-1:0] u_q [3];
	logic signed [WORD_W-1:0] t_q [3];
	logic [3:0] op_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic sel_q;
	logic deg_q;
	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] root_q;
	logic [ACC_W-1:0] bit_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] dv_rem_q;
	logic [QB-1:0] dv_low_q;
	logic [4:0] dv_cnt_q;
	logic [1:0] comp_q;
	logic [1:0] grp_q;

	// Operand selection for the shared multiplier.
	logic signed [OPW-1:0] opa;
	logic signed [OPW-1:0] opb;
	logic op_sub;
	logic grp_first;
	logic grp_end;
	logic all_done;
	logic [1:0] grp_idx;

	always_comb begin
		opa = '0;
		opb = '0;
		op_sub = 1'b0;
		grp_first = 1'b0;
		grp_end = 1'b0;
		all_done = 1'b0;
		grp_idx = 2'd0;
		unique case (phase_q)
			PH_SQ: begin
				opa = OPW'(mag_q[op_q[1:0]][NMAG_W-1:0]);
				opb = OPW'(mag_q[op_q[1:0]][NMAG_W-1:0]);
				grp_first = (op_q == 4'd0);
				grp_end = (op_q == 4'd2);
				all_done = (op_q == 4'd2);
			end
			PH_CROSS: begin
				op_sub = op_q[0];
				grp_first = !op_q[0];
				grp_end = op_q[0];
				grp_idx = op_q[2:1];
				all_done = (op_q == 4'd5);
				priority case (op_q)
					4'd0: begin opa = OPW'(up_q[1]); opb = OPW'(f_q[2]); end
					4'd1: begin opa = OPW'(up_q[2]); opb = OPW'(f_q[1]); end
					4'd2: begin opa = OPW'(up_q[2]); opb = OPW'(f_q[0]); end
					4'd3: begin opa = OPW'(up_q[0]); opb = OPW'(f_q[2]); end
					4'd4: begin opa = OPW'(up_q[0]); opb = OPW'(f_q[1]); end
					default: begin opa = OPW'(up_q[1]); opb = OPW'(f_q[0]); end
				endcase
			end
			PH_UP: begin
				op_sub = op_q[0];
				grp_first = !op_q[0];
				grp_end = op_q[0];
				grp_idx = op_q[2:1];
				all_done = (op_q == 4'd5);
				priority case (op_q)
					4'd0: begin opa = OPW'(f_q[1]); opb = OPW'(l_q[2]); end
					4'd1: begin opa = OPW'(f_q[2]); opb = OPW'(l_q[1]); end
					4'd2: begin opa = OPW'(f_q[2]); opb = OPW'(l_q[0]); end
					4'd3: begin opa = OPW'(f_q[0]); opb = OPW'(l_q[2]); end
					4'd4: begin opa = OPW'(f_q[0]); opb = OPW'(l_q[1]); end
					default: begin opa = OPW'(f_q[1]); opb = OPW'(l_q[0]); end
				endcase
			end
			PH_DOT: begin
				all_done = (op_q == 4'd8);
				priority case (op_q)
					4'd0: begin opa = OPW'(l_q[0]); opb = OPW'(eye_q[0]); grp_first = 1'b1; end
					4'd1: begin opa = OPW'(l_q[1]); opb = OPW'(eye_q[1]); end
					4'd2: begin
						opa = OPW'(l_q[2]); opb = OPW'(eye_q[2]); grp_end = 1'b1;
					end
					4'd3: begin
						opa = OPW'(u_q[0]); opb = OPW'(eye_q[0]); grp_first = 1'b1;
						grp_idx = 2'd1;
					end
					4'd4: begin opa = OPW'(u_q[1]); opb = OPW'(eye_q[1]); grp_idx = 2'd1; end
					4'd5: begin
						opa = OPW'(u_q[2]); opb = OPW'(eye_q[2]); grp_end = 1'b1;
						grp_idx = 2'd1;
					end
					4'd6: begin
						opa = OPW'(f_q[0]); opb = OPW'(eye_q[0]); grp_first = 1'b1;
						grp_idx = 2'd2;
					end
					4'd7: begin opa = OPW'(f_q[1]); opb = OPW'(eye_q[1]); grp_idx = 2'd2; end
					default: begin
						opa = OPW'(f_q[2]); opb = OPW'(eye_q[2]); grp_end = 1'b1;
						grp_idx = 2'd2;
					end
				endcase
			end
		endcase
	end

	// Accumulator update and the values written at the end of a product group.
	logic signed [ACC_W-1:0] prod_w;
	logic signed [ACC_W-1:0] acc_n;
	logic signed [ACC_W-1:0] acc_abs;
	logic signed [ACC_W-1:0] up_rnd;
	logic signed [ACC_W-1:0] dot_rnd;

	always_comb begin
		prod_w = prod_q[ACC_W-1:0];
		acc_n = (grp_first ? '0 : acc_q) + (op_sub ? -prod_w : prod_w);
		acc_abs = acc_n[ACC_W-1] ? -acc_n : acc_n;
		up_rnd = rnd(acc_n);
		dot_rnd = rnd(-acc_n);
	end

	// Normalization tests on the scaled magnitudes.
	logic mag_zero;
	logic mag_hi;
	logic mag_lo;

	always_comb begin
		mag_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
		mag_hi = (|mag_q[0][MAG_W-1:NMAG_W]) || (|mag_q[1][MAG_W-1:NMAG_W])
			|| (|mag_q[2][MAG_W-1:NMAG_W]);
		mag_lo = (mag_q[0][MAG_W-1:NMAG_W-1] == '0) && (mag_q[1][MAG_W-1:NMAG_W-1] == '0)
			&& (mag_q[2][MAG_W-1:NMAG_W-1] == '0);
	end

	// One square-root step and one divider step.
	logic [ACC_W:0] sq_trial;
	logic sq_take;
	logic [ACC_W-1:0] root_n;
	logic [LEN_W:0] dv_trial;
	logic dv_take;
	logic [QB-1:0] dv_low_n;
	logic [NUM_W-1:0] num;
	logic signed [FW-1:0] q_signed;

	always_comb begin
		sq_trial = (ACC_W+1)'(root_q) + (ACC_W+1)'(bit_q);
		sq_take = (ACC_W+1)'(rem_q) >= sq_trial;
		root_n = sq_take ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		dv_trial = {dv_rem_q, dv_low_q[QB-1]} - {1'b0, len_q};
		dv_take = !dv_trial[LEN_W];
		dv_low_n = {dv_low_q[QB-2:0], dv_take};
		num = (NUM_W'(mag_q[comp_q][NMAG_W-1:0]) << FRAC) + NUM_W'(len_q >> 1);
		q_signed = neg_q[comp_q] ? -FW'(dv_low_n) : FW'(dv_low_n);
	end

	// Input move arithmetic.
	cmd_t in_cmd;
	logic [1:0] axis;
	assign in_cmd = cmd_t'(s_axis_tuser);
	assign axis = s_axis_tuser;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Main sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SQ;
			up_q[0] <= '0; up_q[1] <= ONE; up_q[2] <= '0;
			eye_q[0] <= '0; eye_q[1] <= '0; eye_q[2] <= ONE;
			tgt_q[0] <= '0; tgt_q[1] <= '0; tgt_q[2] <= '0;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= '0;
				neg_q[i] <= 1'b0;
				f_q[i] <= '0;
				l_q[i] <= '0;
				u_q[i] <= '0;
				t_q[i] <= '0;
			end
			op_q <= '0;
			prod_q <= '0;
			acc_q <= '0;
			sel_q <= 1'b0;
			deg_q <= 1'b0;
			rem_q <= '0;
			root_q <= '0;
			bit_q <= '0;
			len_q <= '0;
			dv_rem_q <= '0;
			dv_low_q <= '0;
			dv_cnt_q <= '0;
			comp_q <= '0;
			grp_q <= '0;
		end else begin
			// Configuration writes; indexes past the up vector are dropped.
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_UP_X: up_q[0] <= cfg_data;
					REG_UP_Y: up_q[1] <= cfg_data;
					REG_UP_Z: up_q[2] <= cfg_data;
					REG_NONE: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (in_cmd == CMD_VIEW) begin
							for (int i = 0; i < 3; i++) begin
								logic signed [WORD_W:0] d;
								d = (WORD_W+1)'(eye_q[i]) - (WORD_W+1)'(tgt_q[i]);
								neg_q[i] <= d[WORD_W];
								mag_q[i] <= d[WORD_W] ? MAG_W'(-d) : MAG_W'(d);
							end
							sel_q <= 1'b0;
							deg_q <= 1'b0;
							state_q <= ST_NORM;
						end else begin
							eye_q[axis] <= sat_add(eye_q[axis], s_axis_tdata);
							tgt_q[axis] <= sat_add(tgt_q[axis], s_axis_tdata);
						end
					end
				end

				ST_NORM: begin
					if (mag_zero) begin
						for (int i = 0; i < 3; i++) begin
							if (sel_q) l_q[i] <= '0;
							else f_q[i] <= '0;
						end
						deg_q <= 1'b1;
						phase_q <= sel_q ? PH_UP : PH_CROSS;
						op_q <= '0;
						state_q <= ST_MUL;
					end else if (mag_hi) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (mag_lo) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						phase_q <= PH_SQ;
						op_q <= '0;
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					prod_q <= opa * opb;
					state_q <= ST_ACC;
				end

				ST_ACC: begin
					acc_q <= acc_n;
					if (grp_end) begin
						unique case (phase_q)
							PH_SQ: ;
							PH_CROSS: begin
								mag_q[grp_idx] <= acc_abs[MAG_W-1:0];
								neg_q[grp_idx] <= acc_n[ACC_W-1];
							end
							PH_UP: u_q[grp_idx] <= up_rnd[UW-1:0];
							PH_DOT: t_q[grp_idx] <= clamp_word(dot_rnd);
						endcase
					end
					if (all_done) begin
						unique case (phase_q)
							PH_SQ: begin
								rem_q <= acc_n;
								root_q <= '0;
								bit_q <= ACC_W'(1) << (ACC_W - 2);
								state_q <= ST_SQRT;
							end
							PH_CROSS: begin
								sel_q <= 1'b1;
								state_q <= ST_NORM;
							end
							PH_UP: begin
								phase_q <= PH_DOT;
								op_q <= '0;
								state_q <= ST_MUL;
							end
							PH_DOT: begin
								grp_q <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end else begin
						op_q <= op_q + 4'd1;
						state_q <= ST_MUL;
					end
				end

				ST_SQRT: begin
					if (sq_take) rem_q <= rem_q - sq_trial[ACC_W-1:0];
					root_q <= root_n;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						len_q <= root_n[LEN_W-1:0];
						comp_q <= '0;
						state_q <= ST_DLOAD;
					end
				end

				ST_DLOAD: begin
					dv_rem_q <= LEN_W'(num >> QB);
					dv_low_q <= num[QB-1:0];
					dv_cnt_q <= '0;
					state_q <= ST_DIV;
				end

				ST_DIV: begin
					if (dv_take) dv_rem_q <= dv_trial[LEN_W-1:0];
					else dv_rem_q <= {dv_rem_q[LEN_W-2:0], dv_low_q[QB-1]};
					dv_low_q <= dv_low_n;
					dv_cnt_q <= dv_cnt_q + 5'd1;
					if (dv_cnt_q == 5'(QB - 1)) begin
						if (sel_q) l_q[comp_q] <= q_signed;
						else f_q[comp_q] <= q_signed;
						if (comp_q == 2'd2) begin
							phase_q <= sel_q ? PH_UP : PH_CROSS;
							op_q <= '0;
							state_q <= ST_MUL;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end
				end

				ST_OUT: begin
					if (m_axis_tready) begin
						grp_q <= grp_q + 2'd1;
						if (grp_q == 2'd3) state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result group assembly.
	always_comb begin
		if (grp_q == 2'd3) begin
			m_axis_tdata = {ONE, t_q[2], t_q[1], t_q[0]};
		end else begin
			m_axis_tdata = {WORD_W'(0), WORD_W'(f_q[grp_q]), WORD_W'(u_q[grp_q]),
				WORD_W'(l_q[grp_q])};
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tuser = {deg_q, grp_q};
	assign m_axis_tlast = (grp_q == 2'd3);

	// The final group hands control back to the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("input not reopened after last group");

	// A view transaction closes the input side on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_VIEW) |=> !s_axis_tready)
		else $error("input still open after view request");

	// Input and output sides are never open at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while results pending");

	// The divider never runs with a zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (len_q != '0))
		else $error("division by zero length");

endmodule

@@ tb/look_at_view_matrix_tb.sv @@
// Self-checking testbench for the look-at view matrix block with a scoreboard class.
`timescale 1ns / 1ps

module look_at_view_matrix_tb;
	import lav_pkg::*;

	// Tracks camera state and up vector, predicts the four matrix groups of each view.
	class view_scoreboard;
		typedef struct {
			logic [1:0]        grp;
			logic [3:0][31:0]  ent;
			logic              deg;
			logic              last;
		} matrix_group_t;

		longint up_vec[3];
		longint eye[3];
		longint tgt[3];
		matrix_group_t groups_due[$];
		int errors;

		function new();
			up_vec = '{0, 65536, 0};
			eye = '{0, 0, 65536};
			tgt = '{0, 0, 0};
			errors = 0;
		endfunction

		function void write_up(reg_idx_t idx, logic [31:0] val);
			if (idx != REG_NONE) begin
				up_vec[idx] = longint'($signed(val));
			end
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Shift right by the fraction width with rounding half toward plus infinity.
		function longint round_frac(longint x);
			return (x + 64'sd32768) >>> 16;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Returns 1 when the vector has zero length.
		function bit unit_vector(input longint v[3], output longint o[3]);
			longint unsigned m[3];
			longint unsigned mx;
			longint unsigned len;
			longint q;
			for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
			mx = m[0];
			if (m[1] > mx) mx = m[1];
			if (m[2] > mx) mx = m[2];
			if (mx == 0) begin
				o = '{0, 0, 0};
				return 1'b1;
			end
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			while (mx < (64'd1 << 29)) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++) m[i] <<= 1;
			end
			len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 16) + len / 2) / len;
				o[i] = v[i] < 0 ? -q : q;
			end
			return 1'b0;
		endfunction

		function longint neg_dot(longint v[3], longint e[3]);
			longint acc;
			acc = v[0] * e[0] + v[1] * e[1] + v[2] * e[2];
			return clamp32(round_frac(-acc));
		endfunction

		// Apply one accepted input transaction to the camera state.
		function void note_input(cmd_t cmd, logic [31:0] amount);
			longint a;
			longint fd[3], fw[3], cr[3], lf[3], uv[3];
			longint mat[4][4];
			bit deg;
			matrix_group_t grp;
			a = longint'($signed(amount));
			if (cmd != CMD_VIEW) begin
				eye[cmd] = clamp32(eye[cmd] + a);
				tgt[cmd] = clamp32(tgt[cmd] + a);
				return;
			end
			for (int i = 0; i < 3; i++) fd[i] = eye[i] - tgt[i];
			deg = unit_vector(fd, fw);
			cr[0] = up_vec[1] * fw[2] - up_vec[2] * fw[1];
			cr[1] = up_vec[2] * fw[0] - up_vec[0] * fw[2];
			cr[2] = up_vec[0] * fw[1] - up_vec[1] * fw[0];
			if (unit_vector(cr, lf)) deg = 1'b1;
			uv[0] = round_frac(fw[1] * lf[2] - fw[2] * lf[1]);
			uv[1] = round_frac(fw[2] * lf[0] - fw[0] * lf[2]);
			uv[2] = round_frac(fw[0] * lf[1] - fw[1] * lf[0]);
			for (int g = 0; g < 3; g++) begin
				mat[g][0] = lf[g];
				mat[g][1] = uv[g];
				mat[g][2] = fw[g];
				mat[g][3] = 0;
			end
			mat[3][0] = neg_dot(lf, eye);
			mat[3][1] = neg_dot(uv, eye);
			mat[3][2] = neg_dot(fw, eye);
			mat[3][3] = 65536;
			for (int g = 0; g < 4; g++) begin
				grp.grp = g[1:0];
				for (int j = 0; j < 4; j++) grp.ent[j] = mat[g][j][31:0];
				grp.deg = deg;
				grp.last = (g == 3);
				groups_due = {groups_due, grp};
			end
		endfunction

		// Compare one accepted output transaction with the oldest expected group.
		function void check_group(logic [127:0] data, logic [2:0] user, logic last);
			matrix_group_t want;
			if (groups_due.size() == 0) begin
				$display("%0t: unexpected group, data %h user %h last %b", $time, data, user, last);
				errors++;
				return;
			end
			want = groups_due.pop_front();
			if (user[1:0] !== want.grp) begin
				$display("%0t: group_index expected %0d actual %0d", $time, want.grp, user[1:0]);
				errors++;
			end
			for (int j = 0; j < 4; j++) begin
				if (data[32*j +: 32] !== want.ent[j]) begin
					$display("%0t: group %0d entry %0d expected %h actual %h", $time, want.grp,
						j, want.ent[j], data[32*j +: 32]);
					errors++;
				end
			end
			if (user[2] !== want.deg) begin
				$display("%0t: degenerate expected %b actual %b", $time, want.deg, user[2]);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [WORD_W-1:0] s_axis_tdata = '0;
	logic [CMD_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	view_scoreboard sb = new();
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	bit wide_moves = 1'b0;
	int quiet_cycles = 0;

	look_at_view_matrix uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Output side: random stalls, plus one long hold-off when asked.
	always @(posedge clk) begin
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			repeat (500) @(posedge clk);
			hold_req = 1'b0;
			m_axis_tready <= 1'b1;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 35);
		end
	end

	// Check every output transaction against the predicted groups.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_group(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// Watchdog on cycles in which no transaction of any kind happens.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("look_at_view_matrix_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one input transaction, with an occasional random gap first.
	task automatic send_item(cmd_t cmd, logic [31:0] amount);
		if (!no_idle && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= amount;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, amount);
	endtask

	// Drain all pending groups and let the block settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.groups_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_up(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_up(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
		wait_drained();
		write_reg(REG_UP_X, ux);
		write_reg(REG_UP_Y, uy);
		write_reg(REG_UP_Z, uz);
	endtask

	// Random move amount: mostly small so the camera stays away from the rails.
	function automatic logic [31:0] pick_amount();
		int r;
		r = $urandom_range(99);
		if (wide_moves && r < 30) return $urandom();
		if (r < 10) return $urandom_range(1) ? 32'h0000_0000 : 32'h0001_0000;
		return 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
	endfunction

	// Mostly well-formed runs of moves closed by a view, with some stray views.
	task automatic random_items(int count);
		int n;
		n = 0;
		while (n < count) begin
			repeat ($urandom_range(0, 3)) begin
				send_item(cmd_t'($urandom_range(2)), pick_amount());
				n++;
			end
			send_item(CMD_VIEW, $urandom());
			n++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default view, each move, negative and zero amounts.
		send_item(CMD_VIEW, 32'h0);
		send_item(CMD_MOVE_X, 32'h0001_0000);
		send_item(CMD_VIEW, 32'hFFFF_FFFF);
		send_item(CMD_MOVE_Y, 32'hFFFF_0000);
		send_item(CMD_MOVE_Z, 32'h0003_0000);
		send_item(CMD_VIEW, 32'h0);
		send_item(CMD_MOVE_X, 32'h0000_0000);
		send_item(CMD_MOVE_Y, 32'h0000_0001);
		send_item(CMD_VIEW, 32'h0);

		// Up parallel to forward, then the extremes of the up vector.
		set_up(32'h0, 32'h0, 32'h0001_0000);
		send_item(CMD_MOVE_X, 32'hFFFF_0000);
		send_item(CMD_MOVE_X, 32'h0001_0000);
		send_item(CMD_VIEW, 32'h0);
		set_up(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		write_reg(REG_NONE, 32'h1234_5678);
		send_item(CMD_VIEW, 32'h0);
		random_items(50);

		// Receiver holds off long while the sender keeps offering.
		set_up(32'h7FFF_FFFF, 32'h0, 32'h0);
		hold_req = 1'b1;
		random_items(50);

		// A stretch with no idling on either side.
		set_up(32'h0, 32'h0, 32'h0);
		no_idle = 1'b1;
		random_items(30);
		no_idle = 1'b0;

		set_up($urandom(), $urandom(), $urandom());
		random_items(50);

		set_up(32'h0, 32'h0001_0000, 32'h0);
		random_items(50);

		// Wide moves push the camera onto the rails; eye may end equal to target.
		set_up(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
		wide_moves = 1'b1;
		random_items(50);
		send_item(CMD_MOVE_Z, 32'h7FFF_FFFF);
		send_item(CMD_MOVE_X, 32'h8000_0000);
		send_item(CMD_VIEW, 32'h0);
		send_item(CMD_MOVE_Y, 32'h7FFF_FFFF);
		send_item(CMD_VIEW, 32'h0);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.groups_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.groups_due.size() == 0) begin
			$display("look_at_view_matrix_tb passed");
		end else begin
			$display("look_at_view_matrix_tb failed");
		end
		$finish;
	end

endmodule
